// File: rtl/ctbf_pkg.sv
// ----------------------------------------------------------------------------
// ctbf_pkg
// Shared types and tape format constants for the cassette block framer.
// ----------------------------------------------------------------------------
`default_nettype none

package ctbf_pkg;

    // Command codes carried on the command channel
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_PUSH    = 2'd1,
        OP_END     = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_LOAD_ADDRESS = 2'd0,
        REG_EXEC_ADDRESS = 2'd1,
        REG_FILE_NAME    = 2'd2
    } reg_idx_t;

    localparam int unsigned CNT_W = 8;

    // Tape format bytes
    localparam logic [7:0] TAPE_SYNC      = 8'h55;
    localparam logic [7:0] TAPE_MAGIC     = 8'h3C;
    localparam logic [7:0] TYPE_NAME      = 8'h00;
    localparam logic [7:0] TYPE_DATA      = 8'h01;
    localparam logic [7:0] TYPE_END       = 8'hFF;
    localparam logic [7:0] FILE_TYPE_BIN  = 8'h02;
    localparam logic [7:0] GAP_BYTE       = 8'h00;
    localparam logic [7:0] NAME_PAYLOAD   = 8'd15;
    localparam logic [7:0] IDLE_BYTE      = 8'h00;
    localparam logic [63:0] NAME_RESET    = 64'h2020_2020_2020_2020;

    typedef struct packed {
        logic [15:0] load_address;
        logic [15:0] exec_address;
        logic [63:0] file_name;
    } cfg_regs_t;

    // Buffer port request; addresses are trimmed to the memory depth
    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [CNT_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [1:0] {
        SEL_CONST = 2'd0,
        SEL_MEM   = 2'd1,
        SEL_CKS   = 2'd2
    } byte_sel_t;

    typedef enum logic [1:0] {
        CKS_HOLD  = 2'd0,
        CKS_LOAD  = 2'd1,
        CKS_ADD   = 2'd2,
        CKS_CLEAR = 2'd3
    } cks_op_t;

    // One result in flight between sequencer and output stage
    typedef struct packed {
        logic       tape_valid;
        logic [7:0] byte_val;
        byte_sel_t  sel;
        cks_op_t    cks;
        logic       accepted;
        logic       finished;
    } stage_t;

endpackage

`default_nettype wire

// File: rtl/ctbf_if.sv
// ----------------------------------------------------------------------------
// ctbf channel interfaces
// Command, tape result and configuration write channels (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface ctbf_cmd_if;
    import ctbf_pkg::*;
    logic       valid;
    logic       ready;
    op_t        op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface ctbf_tape_if;
    logic       valid;
    logic       ready;
    logic       tape_valid;
    logic [7:0] tape_byte;
    logic       accepted;
    logic       finished;

    modport source (output valid, output tape_valid, output tape_byte,
                    output accepted, output finished, input ready);
    modport sink (input valid, input tape_valid, input tape_byte,
                  input accepted, input finished, output ready);
endinterface

interface ctbf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/ctbf_cfg_regs.sv
// ----------------------------------------------------------------------------
// ctbf_cfg_regs
// Load/exec address and file name registers behind the write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbf_cfg_regs (
    input  wire logic            clk,
    input  wire logic            rst_n,
    ctbf_cfg_if.sink             cfg,
    output ctbf_pkg::cfg_regs_t  regs
);
    import ctbf_pkg::*;

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LOAD_ADDRESS: regs_next.load_address = cfg.data[15:0];
                REG_EXEC_ADDRESS: regs_next.exec_address = cfg.data[15:0];
                REG_FILE_NAME:    regs_next.file_name    = cfg.data;
                default:          regs_next = regs_reg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.load_address <= 16'h0000;
            regs_reg.exec_address <= 16'h0000;
            regs_reg.file_name    <= NAME_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ctbf_buffer.sv
// ----------------------------------------------------------------------------
// ctbf_buffer
// Block buffer: one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbf_buffer #(
    parameter int unsigned BLOCK_MAX = 255
) (
    input  wire logic           clk,
    input  wire ctbf_pkg::mem_req_t req,
    output logic [7:0]          rdata
);
    import ctbf_pkg::*;

    localparam int unsigned ADDR_W = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
    localparam int unsigned DEPTH  = 2 ** ADDR_W;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    assign rdata = rdata_reg;

    // Writes (leader, name and collect phases) and reads (body
    // phase) never target the same cycle, so no bypass path is needed.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr[ADDR_W-1:0]];
        end
    end

endmodule

`default_nettype wire

// File: rtl/ctbf_sequencer.sv
// ----------------------------------------------------------------------------
// ctbf_sequencer
// Framing state machine: walks leaders, name block and data blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbf_sequencer #(
    parameter int unsigned LEADER_LENGTH = 128,
    parameter int unsigned BLOCK_MAX     = 255
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire ctbf_pkg::op_t      op,
    input  wire logic [7:0]         data_byte,
    input  wire ctbf_pkg::cfg_regs_t regs,
    output ctbf_pkg::mem_req_t      mem_req,
    output ctbf_pkg::stage_t        stage
);
    import ctbf_pkg::*;

    typedef enum logic [7:0] {
        PH_LEAD1   = 8'b0000_0001,
        PH_NAME    = 8'b0000_0010,
        PH_LEAD2   = 8'b0000_0100,
        PH_COLLECT = 8'b0000_1000,
        PH_HEAD    = 8'b0001_0000,
        PH_BODY    = 8'b0010_0000,
        PH_TAIL    = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } phase_t;

    // Name block byte positions
    localparam logic [CNT_W-1:0] NP_MAGIC = 8'd1;
    localparam logic [CNT_W-1:0] NP_TYPE  = 8'd2;
    localparam logic [CNT_W-1:0] NP_LEN   = 8'd3;
    localparam logic [CNT_W-1:0] NP_BODY  = 8'd4;
    localparam logic [CNT_W-1:0] NP_CKS   = NP_BODY + NAME_PAYLOAD;
    localparam logic [CNT_W-1:0] HP_TYPE  = 8'd2;

    localparam logic [CNT_W:0]   LEAD_LEN = (CNT_W+1)'(LEADER_LENGTH);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BLOCK_MAX);

    phase_t           phase_reg, phase_next, phase_eff;
    logic [CNT_W-1:0] pos_reg, pos_next, pos_eff;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             end_seen_reg, end_seen_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   pos_inc;
    logic [CNT_W-1:0] name_k;
    logic [15:0]      exec_eff;
    logic [7:0]       name_val;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            return c - 8'h20;
        end
        return c;
    endfunction

    assign exec_eff = (regs.exec_address != 16'h0000) ? regs.exec_address
                                                      : regs.load_address;
    assign name_k   = pos_eff - NP_BODY;

    always_comb
    begin
        case (name_k[3:0])
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7:
                name_val = upcase(regs.file_name[63 - 8*name_k[2:0] -: 8]);
            4'd8:    name_val = FILE_TYPE_BIN;
            4'd9:    name_val = GAP_BYTE;
            4'd10:   name_val = GAP_BYTE;
            4'd11:   name_val = exec_eff[15:8];
            4'd12:   name_val = exec_eff[7:0];
            4'd13:   name_val = regs.load_address[15:8];
            default: name_val = regs.load_address[7:0];
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        fill_next     = fill_reg;
        end_seen_next = end_seen_reg;
        done_next     = done_reg;
        phase_eff     = phase_reg;
        pos_eff       = pos_reg;
        pos_inc       = '0;
        mem_req       = '0;
        stage         = '0;
        stage.byte_val = IDLE_BYTE;
        stage.sel     = SEL_CONST;
        stage.cks     = CKS_HOLD;

        unique case (op)
            OP_TICK:
            begin
                // A full buffer, or end of data, starts the next block
                if (phase_reg == PH_COLLECT && (fill_reg >= FULL_CNT || end_seen_reg))
                begin
                    phase_eff = PH_HEAD;
                    pos_eff   = '0;
                end
                phase_next = phase_eff;
                pos_next   = pos_eff;
                pos_inc    = {1'b0, pos_eff} + (CNT_W+1)'(1);

                unique case (phase_eff) inside
                    PH_LEAD1, PH_LEAD2:
                    begin
                        stage.tape_valid = 1'b1;
                        stage.byte_val   = TAPE_SYNC;
                        pos_next         = pos_inc[CNT_W-1:0];
                        if (pos_inc >= LEAD_LEN)
                        begin
                            phase_next = (phase_eff == PH_LEAD1) ? PH_NAME : PH_COLLECT;
                            pos_next   = '0;
                        end
                    end
                    PH_NAME:
                    begin
                        stage.tape_valid = 1'b1;
                        pos_next         = pos_inc[CNT_W-1:0];
                        if (pos_eff == '0)
                        begin
                            stage.byte_val = TAPE_SYNC;
                        end
                        else if (pos_eff == NP_MAGIC)
                        begin
                            stage.byte_val = TAPE_MAGIC;
                        end
                        else if (pos_eff == NP_TYPE)
                        begin
                            stage.byte_val = TYPE_NAME;
                            stage.cks      = CKS_LOAD;
                        end
                        else if (pos_eff == NP_LEN)
                        begin
                            stage.byte_val = NAME_PAYLOAD;
                            stage.cks      = CKS_ADD;
                        end
                        else if (pos_eff < NP_CKS)
                        begin
                            stage.byte_val = name_val;
                            stage.cks      = CKS_ADD;
                        end
                        else if (pos_eff == NP_CKS)
                        begin
                            stage.sel = SEL_CKS;
                        end
                        else
                        begin
                            stage.byte_val = TAPE_SYNC;
                            phase_next     = PH_LEAD2;
                            pos_next       = '0;
                        end
                    end
                    PH_HEAD:
                    begin
                        stage.tape_valid = 1'b1;
                        pos_next         = pos_inc[CNT_W-1:0];
                        if (pos_eff == '0)
                        begin
                            stage.byte_val = TAPE_SYNC;
                        end
                        else if (pos_eff == NP_MAGIC)
                        begin
                            stage.byte_val = TAPE_MAGIC;
                        end
                        else if (pos_eff == HP_TYPE)
                        begin
                            stage.byte_val = (fill_reg != '0) ? TYPE_DATA : TYPE_END;
                            stage.cks      = CKS_LOAD;
                        end
                        else
                        begin
                            stage.byte_val = fill_reg;
                            stage.cks      = CKS_ADD;
                            phase_next     = (fill_reg != '0) ? PH_BODY : PH_TAIL;
                            pos_next       = '0;
                        end
                    end
                    PH_BODY:
                    begin
                        stage.tape_valid = 1'b1;
                        stage.sel        = SEL_MEM;
                        stage.cks        = CKS_ADD;
                        mem_req.re       = 1'b1;
                        mem_req.raddr    = pos_eff;
                        pos_next         = pos_inc[CNT_W-1:0];
                        if (pos_inc >= {1'b0, fill_reg})
                        begin
                            phase_next = PH_TAIL;
                            pos_next   = '0;
                        end
                    end
                    PH_TAIL:
                    begin
                        stage.tape_valid = 1'b1;
                        if (pos_eff == '0)
                        begin
                            stage.sel = SEL_CKS;
                            pos_next  = CNT_W'(1);
                        end
                        else
                        begin
                            stage.byte_val = TAPE_SYNC;
                            pos_next       = '0;
                            if (fill_reg != '0)
                            begin
                                fill_next  = '0;
                                phase_next = PH_COLLECT;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                                done_next  = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        // collecting or done: nothing to send
                    end
                endcase
            end
            OP_PUSH:
            begin
                if ((phase_reg inside {PH_LEAD1, PH_NAME, PH_LEAD2, PH_COLLECT})
                    && !end_seen_reg && fill_reg < FULL_CNT)
                begin
                    mem_req.we     = 1'b1;
                    mem_req.waddr  = fill_reg;
                    mem_req.wdata  = data_byte;
                    fill_next      = fill_reg + CNT_W'(1);
                    stage.accepted = 1'b1;
                end
            end
            OP_END:
            begin
                if (!end_seen_reg && phase_reg != PH_DONE)
                begin
                    end_seen_next  = 1'b1;
                    stage.accepted = 1'b1;
                end
            end
            default:
            begin
                phase_next    = PH_LEAD1;
                pos_next      = '0;
                fill_next     = '0;
                end_seen_next = 1'b0;
                done_next     = 1'b0;
                stage.cks     = CKS_CLEAR;
            end
        endcase

        stage.finished = done_next;

        if (!fire)
        begin
            mem_req.we = 1'b0;
            mem_req.re = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEAD1;
            pos_reg      <= '0;
            fill_reg     <= '0;
            end_seen_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            fill_reg     <= fill_next;
            end_seen_reg <= end_seen_next;
            done_reg     <= done_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ctbf_emitter.sv
// ----------------------------------------------------------------------------
// ctbf_emitter
// Output stage: result register, byte select and running checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbf_emitter (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire ctbf_pkg::stage_t stage_in,
    input  wire logic [7:0]       rdata,
    output logic                  ready,
    ctbf_tape_if.source           tape
);
    import ctbf_pkg::*;

    logic       vld_reg, vld_next;
    stage_t     stage_reg;
    logic [7:0] cks_reg, cks_next;
    logic [7:0] out_byte;
    logic       out_fire;

    assign ready    = !vld_reg || tape.ready;
    assign out_fire = vld_reg && tape.ready;

    always_comb
    begin
        case (stage_reg.sel)
            SEL_MEM: out_byte = rdata;
            SEL_CKS: out_byte = cks_reg;
            default: out_byte = stage_reg.byte_val;
        endcase
    end

    // Checksum follows delivered beats, so it sees bytes in stream order
    always_comb
    begin
        cks_next = cks_reg;
        if (out_fire)
        begin
            case (stage_reg.cks)
                CKS_LOAD:  cks_next = out_byte;
                CKS_ADD:   cks_next = cks_reg + out_byte;
                CKS_CLEAR: cks_next = 8'h00;
                default:   cks_next = cks_reg;
            endcase
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_fire)
        begin
            vld_next = 1'b0;
        end
    end

    assign tape.valid      = vld_reg;
    assign tape.tape_valid = stage_reg.tape_valid;
    assign tape.tape_byte  = out_byte;
    assign tape.accepted   = stage_reg.accepted;
    assign tape.finished   = stage_reg.finished;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            cks_reg <= 8'h00;
        end
        else
        begin
            vld_reg <= vld_next;
            cks_reg <= cks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_in;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cassette_tape_block_framer.sv
// ----------------------------------------------------------------------------
// cassette_tape_block_framer
// Frames a program image into a cassette tape byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : command beats (op, data_byte). TICK asks for one tape byte, PUSH
//          loads one image byte into the block buffer, END marks end of
//          data, RESTART returns the framer to the first leader.
//   tape : one result beat per command beat (tape_valid, tape_byte,
//          accepted, finished). tape_valid is low on ticks with nothing
//          to send; tape_byte is then zero.
//   cfg  : register writes (load address, exec address, file name);
//          always ready, to be written while no command is in flight.
// Throughput: one command beat per cycle while tape.ready is high.
// Timing: a result appears in the cycle after its command beat; body bytes
//   come from the buffer's registered read port in that same cycle.
// Stall: the result register holds while tape.ready is low, and cmd.ready
//   drops until it drains, so no beat is lost or repeated.
// Reset: stream restarts at the first leader, buffer empty; the buffer
//   content itself is not cleared (only filled entries are ever read).
// ----------------------------------------------------------------------------
`default_nettype none

module cassette_tape_block_framer #(
    parameter int unsigned LEADER_LENGTH = 128,
    parameter int unsigned BLOCK_MAX     = 255
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ctbf_cfg_if.sink     cfg,
    ctbf_cmd_if.sink     cmd,
    ctbf_tape_if.source  tape
);
    import ctbf_pkg::*;

    cfg_regs_t  regs;
    mem_req_t   mem_req;
    stage_t     stage;
    logic [7:0] rdata;
    logic       stage_ready;
    logic       cmd_fire;

    // Command beat goes straight into the stage register when it is free
    assign cmd.ready = stage_ready;
    assign cmd_fire  = cmd.valid && stage_ready;

    ctbf_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Phase, position, fill count and end flags; issues buffer accesses
    ctbf_sequencer #(
        .LEADER_LENGTH (LEADER_LENGTH),
        .BLOCK_MAX     (BLOCK_MAX)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (cmd_fire),
        .op        (cmd.op),
        .data_byte (cmd.data_byte),
        .regs      (regs),
        .mem_req   (mem_req),
        .stage     (stage)
    );

    ctbf_buffer #(
        .BLOCK_MAX (BLOCK_MAX)
    ) u_buf (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // Result register plus checksum; checksum byte is emitted from here
    ctbf_emitter u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd_fire),
        .stage_in (stage),
        .rdata    (rdata),
        .ready    (stage_ready),
        .tape     (tape)
    );

endmodule

`default_nettype wire

// File: rtl/ctbf_checker.sv
// ----------------------------------------------------------------------------
// ctbf_checker
// Port-level assertions for the framer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cmd_valid,
    input wire logic       cmd_ready,
    input wire logic [1:0] cmd_op,
    input wire logic       tape_vld,
    input wire logic       tape_ready,
    input wire logic [7:0] tape_byte,
    input wire logic       tape_accepted
);
    import ctbf_pkg::*;

    // Each command beat yields a result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> tape_vld)
        else $error("no result after command beat");

    // Empty output stage must take a command
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !tape_vld |-> cmd_ready)
        else $error("stalled with empty output stage");

    // A tick never reports a taken request
    a_tick_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_op == OP_TICK) |=> !tape_accepted)
        else $error("tick flagged as accepted");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tape_vld && !tape_ready |=> tape_vld)
        else $error("result dropped while stalled");

    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        tape_vld && !tape_ready |=> $stable(tape_byte))
        else $error("tape byte changed while stalled");

endmodule

bind cassette_tape_block_framer ctbf_checker u_ctbf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .cmd_op        (cmd.op),
    .tape_vld      (tape.valid),
    .tape_ready    (tape.ready),
    .tape_byte     (tape.tape_byte),
    .tape_accepted (tape.accepted)
);

`default_nettype wire

// File: bench/cassette_tape_block_framer_test.sv
// ----------------------------------------------------------------------------
// cassette_tape_block_framer_test
// Self-checking bench for the cassette tape block framer. A cycle-level
// predictor follows every command beat and keeps the tape beats it should
// produce in a queue. A sink process compares each tape beat field by field.
// Both sides idle at random. One phase holds the tape sink off long enough
// to stall the command channel.
// ----------------------------------------------------------------------------
module cassette_tape_block_framer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ctbf_pkg::*;

    localparam int unsigned LEADER_LENGTH = 128;
    localparam int unsigned BLOCK_MAX     = 255;

    // Stop points for the stimulus, not checked at the end. Any stream gives
    // more work beats than RANDOM_WORK, so the random test runs one stream.
    localparam int unsigned RANDOM_WORK   = 250;
    localparam int unsigned STREAM_CAP    = 2500;

    // One result per command, in the cycle after it; the spare cycles are plenty
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_OFF      = 400;

    // About 1300 items plus the hold-off, taken many times over
    localparam int unsigned CYCLE_LIMIT   = 500000;

    // Stream position of the predictor
    typedef enum logic [2:0] {
        ST_LEADER1,
        ST_NAME,
        ST_LEADER2,
        ST_COLLECT,
        ST_HEAD,
        ST_BODY,
        ST_TAIL,
        ST_DONE
    } frame_state_t;

    typedef struct packed {
        logic       tape_valid;
        logic [7:0] tape_byte;
        logic       accepted;
        logic       finished;
    } tape_beat_t;

    logic clk;
    logic rst_n;

    ctbf_cmd_if  cmd ();
    ctbf_tape_if tape ();
    ctbf_cfg_if  cfg ();

    cassette_tape_block_framer #(
        .LEADER_LENGTH(LEADER_LENGTH),
        .BLOCK_MAX    (BLOCK_MAX)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .cmd  (cmd),
        .tape (tape)
    );

    // ------------------------------------------------------------------
    // Predictor state: the registers as last written, and the framer
    // ------------------------------------------------------------------
    logic [15:0]  prog_base_reg;
    logic [15:0]  entry_point_reg;
    logic [63:0]  file_name_reg;

    frame_state_t fr_state;
    logic [7:0]   fr_pos;
    logic [7:0]   fr_buf [0:255];
    logic [7:0]   fr_fill;
    logic [7:0]   fr_cks;
    logic         fr_end_seen;
    logic         fr_done;

    tape_beat_t   expected_beats [$];
    tape_beat_t   last_beat;        // prediction for the newest command beat
    int unsigned  work_items;       // beats that emitted, took data or restarted
    int unsigned  fail_count;
    int unsigned  cycle_count;
    int unsigned  hold_request;     // sink hold-off asked by a test, in cycles
    bit           idle_on;          // random gaps on both channels

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Back to the first leader; registers stay as they are.
    function automatic void clear_frame();
        fr_state    = ST_LEADER1;
        fr_pos      = '0;
        fr_fill     = '0;
        fr_cks      = '0;
        fr_end_seen = 1'b0;
        fr_done     = 1'b0;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Predictor: one command beat in, the tape beat it causes out
    // ------------------------------------------------------------------
    function automatic tape_beat_t frame_step(op_t op, logic [7:0] data);
        tape_beat_t  r;
        logic [7:0]  b;
        logic [15:0] run_from;
        int          k;

        r = '0;
        b = IDLE_BYTE;
        // zero exec address falls back to the load address
        run_from = (entry_point_reg != 16'h0000) ? entry_point_reg : prog_base_reg;

        case (op)
            OP_TICK:
            begin
                // a full buffer, or end of data, opens the next block
                if (fr_state == ST_COLLECT && (fr_fill >= BLOCK_MAX || fr_end_seen))
                begin
                    fr_state = ST_HEAD;
                    fr_pos   = '0;
                end
                case (fr_state)
                    ST_LEADER1, ST_LEADER2:
                    begin
                        b = TAPE_SYNC;
                        r.tape_valid = 1'b1;
                        fr_pos++;
                        if (fr_pos >= LEADER_LENGTH)
                        begin
                            if (fr_state == ST_LEADER1)
                                fr_state = ST_NAME;
                            else
                                fr_state = ST_COLLECT;
                            fr_pos = '0;
                        end
                    end
                    ST_NAME:
                    begin
                        r.tape_valid = 1'b1;
                        if (fr_pos == 0)
                            b = TAPE_SYNC;
                        else if (fr_pos == 1)
                            b = TAPE_MAGIC;
                        else if (fr_pos == 2)
                        begin
                            b = TYPE_NAME;
                            fr_cks = b;
                        end
                        else if (fr_pos == 3)
                        begin
                            b = NAME_PAYLOAD;
                            fr_cks += b;
                        end
                        else if (fr_pos < 4 + NAME_PAYLOAD)
                        begin
                            k = fr_pos - 4;
                            if (k < 8)
                            begin
                                // name characters, first in the top byte;
                                // lower case a..z raised
                                b = file_name_reg[63 - 8 * k -: 8];
                                if (b >= 8'h61 && b <= 8'h7A)
                                    b = b - 8'h20;
                            end
                            else
                            begin
                                case (k)
                                    8:       b = FILE_TYPE_BIN;
                                    9, 10:   b = GAP_BYTE;
                                    11:      b = run_from[15:8];
                                    12:      b = run_from[7:0];
                                    13:      b = prog_base_reg[15:8];
                                    default: b = prog_base_reg[7:0];
                                endcase
                            end
                            fr_cks += b;
                        end
                        else if (fr_pos == 4 + NAME_PAYLOAD)
                            b = fr_cks;
                        else
                            b = TAPE_SYNC;
                        if (fr_pos >= 5 + NAME_PAYLOAD)
                        begin
                            fr_state = ST_LEADER2;
                            fr_pos   = '0;
                        end
                        else
                            fr_pos++;
                    end
                    ST_HEAD:
                    begin
                        // an empty buffer here means the end block
                        r.tape_valid = 1'b1;
                        if (fr_pos == 0)
                            b = TAPE_SYNC;
                        else if (fr_pos == 1)
                            b = TAPE_MAGIC;
                        else if (fr_pos == 2)
                        begin
                            b = (fr_fill != 0) ? TYPE_DATA : TYPE_END;
                            fr_cks = b;
                        end
                        else
                        begin
                            b = fr_fill;
                            fr_cks += b;
                        end
                        if (fr_pos >= 3)
                        begin
                            if (fr_fill != 0)
                                fr_state = ST_BODY;
                            else
                                fr_state = ST_TAIL;
                            fr_pos = '0;
                        end
                        else
                            fr_pos++;
                    end
                    ST_BODY:
                    begin
                        r.tape_valid = 1'b1;
                        b = fr_buf[fr_pos];
                        fr_cks += b;
                        fr_pos++;
                        if (fr_pos >= fr_fill)
                        begin
                            fr_state = ST_TAIL;
                            fr_pos   = '0;
                        end
                    end
                    ST_TAIL:
                    begin
                        r.tape_valid = 1'b1;
                        if (fr_pos == 0)
                        begin
                            b = fr_cks;
                            fr_pos = 8'd1;
                        end
                        else
                        begin
                            b = TAPE_SYNC;
                            fr_pos = '0;
                            if (fr_fill != 0)
                            begin
                                fr_fill  = '0;
                                fr_state = ST_COLLECT;
                            end
                            else
                            begin
                                fr_state = ST_DONE;
                                fr_done  = 1'b1;
                            end
                        end
                    end
                    default: ;  // waiting for data, or finished: nothing to send
                endcase
            end
            OP_PUSH:
            begin
                // taken up to collect time, while room and before end of data
                if (fr_state <= ST_COLLECT && !fr_end_seen && fr_fill < BLOCK_MAX)
                begin
                    fr_buf[fr_fill] = data;
                    fr_fill++;
                    r.accepted = 1'b1;
                end
            end
            OP_END:
            begin
                if (!fr_end_seen && fr_state != ST_DONE)
                begin
                    fr_end_seen = 1'b1;
                    r.accepted  = 1'b1;
                end
            end
            default: clear_frame();
        endcase

        r.tape_byte = b;
        r.finished  = fr_done;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command driver. Returns at the edge that took the beat, with valid
    // still high, so a back-to-back beat needs no second assignment.
    // ------------------------------------------------------------------
    task automatic send_cmd(op_t op, logic [7:0] data);
        int unsigned gap;

        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.op        <= op;
        cmd.data_byte <= data;
        do @(posedge clk); while (!cmd.ready);
        last_beat = frame_step(op, data);
        expected_beats.push_back(last_beat);
        if (last_beat.tape_valid || last_beat.accepted || op == OP_RESTART)
            work_items++;
    endtask

    // Idle the command channel and let every outstanding beat come back.
    task automatic settle();
        cmd.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(reg_idx_t idx, logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            REG_LOAD_ADDRESS: prog_base_reg = value[15:0];
            REG_EXEC_ADDRESS: entry_point_reg = value[15:0];
            default:          file_name_reg = value;
        endcase
    endtask

    // All three registers, only with the framer idle.
    task automatic write_config(logic [15:0] prog_base, logic [15:0] entry_point,
                                logic [63:0] name);
        settle();
        put_reg(REG_LOAD_ADDRESS, {48'h0, prog_base});
        put_reg(REG_EXEC_ADDRESS, {48'h0, entry_point});
        put_reg(REG_FILE_NAME, name);
        cfg.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tape sink: random stalls, a hold-off on request, and the check
    // ------------------------------------------------------------------
    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endfunction

    initial
    begin : tape_sink
        tape_beat_t  want;
        int unsigned stall;

        tape.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_request != 0)
            begin
                // long hold-off, counted here; the framer fills up behind it
                stall = hold_request;
                hold_request = 0;
            end
            else
                stall = idle_on ? $urandom_range(0, 9) : 0;
            if (stall != 0)
            begin
                tape.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tape.ready <= 1'b1;
            do @(posedge clk); while (!tape.valid);
            if (expected_beats.size() == 0)
            begin
                $error("tape beat with no command outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("tape_valid", {7'h0, want.tape_valid}, {7'h0, tape.tape_valid});
                check_field("tape_byte", want.tape_byte, tape.tape_byte);
                check_field("accepted", {7'h0, want.accepted}, {7'h0, tape.accepted});
                check_field("finished", {7'h0, want.finished}, {7'h0, tape.finished});
            end
        end
    end

    // ------------------------------------------------------------------
    // One stream: mostly well-formed (ticks through leaders and name,
    // image_len pushes, end, ticks to the finish), with a little noise.
    // ------------------------------------------------------------------
    task automatic run_stream(int unsigned image_len);
        int unsigned pushed;
        int unsigned tail;
        int unsigned n;
        int unsigned pick;

        pushed = 0;
        tail   = 0;
        for (n = 0; n < STREAM_CAP && tail < 6; n++)
        begin
            // change the idling now and then so stretches run gap-free
            if (n % 128 == 127)
                idle_on = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 1999);
            if (fr_state == ST_DONE)
            begin
                // after the finish: idle ticks, late push, late end
                tail++;
                case (pick % 3)
                    0:       send_cmd(OP_TICK, rand_byte());
                    1:       send_cmd(OP_PUSH, rand_byte());
                    default: send_cmd(OP_END, rand_byte());
                endcase
            end
            else if (pick < 12)
                send_cmd(OP_PUSH, rand_byte());
            else if (pick < 14)
                send_cmd(OP_END, rand_byte());
            else if (pick < 15)
                send_cmd(OP_RESTART, rand_byte());
            else if (fr_state == ST_COLLECT && !fr_end_seen)
            begin
                if (pushed >= image_len)
                    send_cmd(OP_END, rand_byte());
                else if (pick < 1300)
                begin
                    // rejected once the buffer is full, until a tick drains it
                    send_cmd(OP_PUSH, rand_byte());
                    if (last_beat.accepted)
                        pushed++;
                end
                else
                    send_cmd(OP_TICK, rand_byte());
            end
            else if (fr_state >= ST_HEAD)
            begin
                // block on its way out: pushes bounce, an end is taken
                if (pick < 1800)
                    send_cmd(OP_TICK, rand_byte());
                else if (pick < 1940)
                    send_cmd(OP_PUSH, rand_byte());
                else
                    send_cmd(OP_END, rand_byte());
            end
            else
                send_cmd(OP_TICK, rand_byte());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every command in the first leader, data extremes, repeated end,
    // pushes after end, restarts.
    task automatic test_command_corners();
        idle_on = 1'b1;
        send_cmd(OP_RESTART, 8'h00);
        send_cmd(OP_TICK, 8'hFF);
        send_cmd(OP_PUSH, 8'h00);
        send_cmd(OP_PUSH, 8'hFF);
        send_cmd(OP_PUSH, 8'h5A);
        send_cmd(OP_TICK, 8'h00);
        send_cmd(OP_END, 8'h00);
        send_cmd(OP_END, 8'hFF);
        send_cmd(OP_PUSH, 8'hA5);
        send_cmd(OP_TICK, 8'h00);
        send_cmd(OP_RESTART, 8'hFF);
        send_cmd(OP_TICK, 8'h00);
        send_cmd(OP_END, 8'h00);
        send_cmd(OP_RESTART, 8'h00);
    endtask

    // Whole streams until the work count is reached, normally one. The first
    // uses extreme registers with letters around the case edges, any later
    // ones random registers.
    task automatic test_random_streams();
        int unsigned episode;
        int unsigned stop_at;
        int          i;
        logic [63:0] name;
        logic [15:0] entry_point;

        episode = 0;
        stop_at = work_items + RANDOM_WORK;
        while (work_items < stop_at)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (episode == 0)
                write_config(16'hFFFF, 16'h0000, 64'h6061_7A7B_4140_5A5B);
            else
            begin
                for (i = 0; i < 8; i++)
                begin
                    case ($urandom_range(0, 3))
                        0:       name[8 * i +: 8] = rand_byte();
                        1:       name[8 * i +: 8] = 8'(32'h61 + $urandom_range(0, 25));
                        2:       name[8 * i +: 8] = 8'(32'h41 + $urandom_range(0, 25));
                        default: name[8 * i +: 8] = ($urandom_range(0, 1) != 0) ? 8'h60 : 8'h7B;
                    endcase
                end
                entry_point = ($urandom_range(0, 3) == 0) ? 16'h0000
                                                          : 16'($urandom_range(0, 65535));
                write_config(16'($urandom_range(0, 65535)), entry_point, name);
            end
            send_cmd(OP_RESTART, rand_byte());
            run_stream(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24));
            episode++;
        end
    endtask

    // A full block and a one-byte remainder, with the sink held off at the
    // start so the command channel backs up.
    task automatic test_full_block_under_backpressure();
        write_config(16'h0000, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        idle_on = 1'b0;
        hold_request = HOLD_OFF;
        send_cmd(OP_RESTART, 8'h00);
        run_stream(BLOCK_MAX + 1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        cmd.valid     <= 1'b0;
        cmd.op        <= OP_TICK;
        cmd.data_byte <= 8'h00;
        cfg.valid     <= 1'b0;
        cfg.index     <= REG_LOAD_ADDRESS;
        cfg.data      <= 64'h0;

        prog_base_reg   = 16'h0000;
        entry_point_reg = 16'h0000;
        file_name_reg   = NAME_RESET;
        clear_frame();
        work_items   = 0;
        fail_count   = 0;
        hold_request = 0;
        idle_on      = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_command_corners();
        test_random_streams();
        test_full_block_under_backpressure();
        settle();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
